@@ src/pulse_energy_top_sum_assert.svh @@
// ----------------------------------------------------------------------------
// pulse_energy_top_sum_assert.svh
// Assertion macros used by the checker of the pulse energy block.
// ----------------------------------------------------------------------------
`ifndef PULSE_ENERGY_TOP_SUM_ASSERT_SVH
`define PULSE_ENERGY_TOP_SUM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PETS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pulse_energy_top_sum: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PETS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pulse_energy_top_sum: assertion failed");

`endif

@@ src/pets_pkg.sv @@
// ----------------------------------------------------------------------------
// pets_pkg
// Shared constants and types of the pulse energy top-sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package pets_pkg;

  // parameter defaults
  localparam int NUM_SAMPLES_DEF = 20;
  localparam int PED_SAMPLES_DEF = 3;
  localparam int TOP_COUNT_DEF   = 4;
  localparam int ADC_BITS_DEF    = 10;

  // fixed field widths
  localparam int TOT_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int ENERGY_W  = 15;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_TOT_MODE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOT_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [TOT_W-1:0] TOT_THRESHOLD_RST = TOT_W'(50);

  // job queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  // per-channel flags that ride along with a job
  typedef struct packed {
    logic             use_tot;
    logic [TOT_W-1:0] first_tot;
    logic             tot_over;
  } job_meta_t;

endpackage

`default_nettype wire

@@ src/pets_fifo.sv @@
// ----------------------------------------------------------------------------
// pets_fifo
// Short register queue holding finished channel jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pets_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import pets_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_en_i && !wr_en_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/pets_front.sv @@
// ----------------------------------------------------------------------------
// pets_front
// Sample intake: pedestal sum, sorted top-N list, ToT tracking, job push.
// ----------------------------------------------------------------------------
`default_nettype none

module pets_front #(
  parameter int NUM_SAMPLES = 20,
  parameter int PED_SAMPLES = 3,
  parameter int TOP_COUNT   = 4,
  parameter int ADC_BITS    = 10,
  parameter int PED_W       = ADC_BITS + $clog2(PED_SAMPLES + 1),
  parameter int TSUM_W      = ADC_BITS + $clog2(TOP_COUNT + 1),
  parameter int FILL_W      = $clog2(TOP_COUNT + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ADC_BITS-1:0]         sample_adc_i,
  input  wire logic [pets_pkg::TOT_W-1:0]  sample_tot_i,
  input  wire logic [pets_pkg::GAIN_W-1:0] channel_gain_i,
  input  wire logic                        tot_mode_i,
  input  wire logic [pets_pkg::TOT_W-1:0]  tot_threshold_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output logic      [PED_W-1:0]            job_ped_o,
  output logic      [TSUM_W-1:0]           job_tsum_o,
  output logic      [FILL_W-1:0]           job_fill_o,
  output logic      [pets_pkg::GAIN_W-1:0] job_gain_o,
  output pets_pkg::job_meta_t              job_meta_o
);
  import pets_pkg::*;

  localparam int CNT_W = $clog2(NUM_SAMPLES);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [PED_W-1:0]    ped_q, ped_d, ped_nx;
  logic [TSUM_W-1:0]   tsum_q, tsum_d, tsum_nx;
  logic [FILL_W-1:0]   fill_q, fill_d, fill_nx;
  logic [ADC_BITS-1:0] top_q [TOP_COUNT];
  logic [ADC_BITS-1:0] top_d [TOP_COUNT];
  logic [ADC_BITS-1:0] top_ins [TOP_COUNT];
  logic [TOT_W-1:0]    ftot_q, ftot_d, ftot_nx;
  logic                over_q, over_d, over_nx;

  logic [TOP_COUNT-1:0] keep;
  logic                 accept, is_last, is_ped, do_ins, full_list;
  logic [ADC_BITS-1:0]  dropped;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_last    = (count_q == CNT_W'(NUM_SAMPLES - 1));
  assign is_ped     = (count_q < CNT_W'(PED_SAMPLES));

  // insertion cells: an entry stays if it is valid and not below the new sample,
  // the first entry that does not stay takes the sample, the rest shift down
  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_cell
    assign keep[k] = (FILL_W'(k) < fill_q) && (top_q[k] >= sample_adc_i);
    if (k == 0) begin : g_head
      assign top_ins[k] = keep[k] ? top_q[k] : sample_adc_i;
    end else begin : g_body
      assign top_ins[k] = keep[k]     ? top_q[k]     :
                          keep[k - 1] ? sample_adc_i : top_q[k - 1];
    end
  end

  assign full_list = (fill_q == FILL_W'(TOP_COUNT));
  assign do_ins    = !keep[TOP_COUNT-1];
  assign dropped   = full_list ? top_q[TOP_COUNT-1] : '0;

  always_comb begin
    ped_nx  = ped_q;
    tsum_nx = tsum_q;
    fill_nx = fill_q;
    if (is_ped) begin
      ped_nx = ped_q + PED_W'(sample_adc_i);
    end else if (do_ins) begin
      tsum_nx = tsum_q + TSUM_W'(sample_adc_i) - TSUM_W'(dropped);
      if (!full_list) begin
        fill_nx = fill_q + FILL_W'(1);
      end
    end
    ftot_nx = ((ftot_q == '0) && (sample_tot_i != '0)) ? sample_tot_i : ftot_q;
    over_nx = over_q || (sample_tot_i > tot_threshold_i);
  end

  always_comb begin
    count_d = count_q;
    ped_d   = ped_q;
    tsum_d  = tsum_q;
    fill_d  = fill_q;
    top_d   = top_q;
    ftot_d  = ftot_q;
    over_d  = over_q;
    if (accept) begin
      if (is_last) begin
        count_d = '0;
        ped_d   = '0;
        tsum_d  = '0;
        fill_d  = '0;
        ftot_d  = '0;
        over_d  = 1'b0;
        for (int i = 0; i < TOP_COUNT; i++) begin
          top_d[i] = '0;
        end
      end else begin
        count_d = count_q + CNT_W'(1);
        ped_d   = ped_nx;
        tsum_d  = tsum_nx;
        fill_d  = fill_nx;
        ftot_d  = ftot_nx;
        over_d  = over_nx;
        if (!is_ped && do_ins) begin
          top_d = top_ins;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ped_q   <= '0;
      tsum_q  <= '0;
      fill_q  <= '0;
      ftot_q  <= '0;
      over_q  <= 1'b0;
      for (int i = 0; i < TOP_COUNT; i++) begin
        top_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      ped_q   <= ped_d;
      tsum_q  <= tsum_d;
      fill_q  <= fill_d;
      ftot_q  <= ftot_d;
      over_q  <= over_d;
      top_q   <= top_d;
    end
  end

  assign push_o               = accept && is_last;
  assign job_ped_o            = ped_nx;
  assign job_tsum_o           = tsum_nx;
  assign job_fill_o           = fill_nx;
  assign job_gain_o           = channel_gain_i;
  assign job_meta_o.use_tot   = tot_mode_i && (ftot_nx != '0);
  assign job_meta_o.first_tot = ftot_nx;
  assign job_meta_o.tot_over  = over_nx;

endmodule

`default_nettype wire

@@ src/pets_back.sv @@
// ----------------------------------------------------------------------------
// pets_back
// Energy pipeline: difference, gain multiply, saturate, floor divide, output.
// ----------------------------------------------------------------------------
`default_nettype none

module pets_back #(
  parameter int PED_SAMPLES = 3,
  parameter int TOP_COUNT   = 4,
  parameter int ADC_BITS    = 10,
  parameter int PED_W       = ADC_BITS + $clog2(PED_SAMPLES + 1),
  parameter int TSUM_W      = ADC_BITS + $clog2(TOP_COUNT + 1),
  parameter int FILL_W      = $clog2(TOP_COUNT + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  output logic                               pop_o,
  input  wire logic [PED_W-1:0]              job_ped_i,
  input  wire logic [TSUM_W-1:0]             job_tsum_i,
  input  wire logic [FILL_W-1:0]             job_fill_i,
  input  wire logic [pets_pkg::GAIN_W-1:0]   job_gain_i,
  input  wire pets_pkg::job_meta_t           job_meta_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [pets_pkg::ENERGY_W-1:0] energy_out_o,
  output logic                               tot_used_o,
  output logic                               tot_over_o
);
  import pets_pkg::*;

  localparam int DIFF_W = ADC_BITS + $clog2(PED_SAMPLES + 1) + $clog2(TOP_COUNT + 1) + 1;
  localparam int NUM_W  = DIFF_W + GAIN_W + 1;
  localparam int YW     = NUM_W - 8;
  // offset value after clamping, always below 2^UW
  localparam int UW     = $clog2(32768 * PED_SAMPLES);
  localparam int RSH    = UW;
  localparam int MW     = RSH + 1;
  localparam logic [MW-1:0] RECIP = MW'((2 ** RSH) / PED_SAMPLES);
  localparam logic signed [YW-1:0] Y_LO = YW'(-16384 * PED_SAMPLES);
  localparam logic signed [YW-1:0] Y_HI = YW'(16384 * PED_SAMPLES - 1);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  job_meta_t m1_q, m2_q, m3_q, m4_q;

  logic        [DIFF_W-1:0]   pos_term, neg_term;
  logic signed [DIFF_W-1:0]   diff_q;
  logic        [GAIN_W-1:0]   gain_q;
  logic signed [NUM_W-1:0]    num_d, num_q;
  logic signed [NUM_W+5:0]    num_ext;
  logic signed [YW-1:0]       y, y_cl, u_full;
  logic        [UW-1:0]       u3_q, u4_q, q0_d, q0_q, rem, q_fin;
  logic        [UW+MW-1:0]    prod;
  logic        [ENERGY_W-1:0] adc_e;
  logic signed [ENERGY_W-1:0] energy_q;
  logic                       used_q, over_q;

  // whole pipeline moves together whenever the output register can take data
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !q_empty_i;

  // stage 1: PED*topsum - filled*pedsum
  assign pos_term = DIFF_W'(job_tsum_i) * DIFF_W'(PED_SAMPLES);
  assign neg_term = DIFF_W'(job_fill_i) * DIFF_W'(job_ped_i);

  // stage 2: gain multiply
  assign num_d = diff_q * $signed({1'b0, gain_q});

  // stage 3: floor by 2^14, clamp to the range that maps onto the output,
  // then move to an unsigned offset for the divide
  assign num_ext = (NUM_W + 6)'(num_q);
  assign y       = $signed(num_ext[NUM_W+5:GAIN_FRAC]);
  assign y_cl    = (y < Y_LO) ? Y_LO : ((y > Y_HI) ? Y_HI : y);
  assign u_full  = y_cl - Y_LO;

  // stage 4: reciprocal estimate, at most one below the true quotient
  assign prod = (UW + MW)'(u3_q) * (UW + MW)'(RECIP);
  assign q0_d = prod[RSH+UW-1:RSH];

  // stage 5: one correction step; removing the offset flips the sign bit
  assign rem   = u4_q - q0_q * UW'(PED_SAMPLES);
  assign q_fin = (rem >= UW'(PED_SAMPLES)) ? q0_q + UW'(1) : q0_q;
  assign adc_e = {~q_fin[ENERGY_W-1], q_fin[ENERGY_W-2:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= $signed(pos_term - neg_term);
      gain_q <= job_gain_i;
      m1_q   <= job_meta_i;
      num_q  <= num_d;
      m2_q   <= m1_q;
      u3_q   <= u_full[UW-1:0];
      m3_q   <= m2_q;
      q0_q   <= q0_d;
      u4_q   <= u3_q;
      m4_q   <= m3_q;
      energy_q <= m4_q.use_tot ? $signed(ENERGY_W'(m4_q.first_tot)) : $signed(adc_e);
      used_q   <= m4_q.use_tot;
      over_q   <= m4_q.tot_over;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign energy_out_o = energy_q;
  assign tot_used_o   = used_q;
  assign tot_over_o   = over_q;

endmodule

`default_nettype wire

@@ src/pulse_energy_top_sum.sv @@
// ----------------------------------------------------------------------------
// pulse_energy_top_sum
// Pedestal-subtracted top-N peak sum per readout channel, with ToT override.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_stall_o     sample_adc_i, sample_tot_i,
//                                                  channel_gain_i
//  out      output     out_valid_o / out_stall_i   energy_out_o, tot_used_o,
//                                                  tot_over_o
//  cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
//  One sample transfer per cycle while the input is not stalled; a channel is
//  NUM_SAMPLES transfers. After the last sample transfer of a channel its job
//  is written to the queue, then passes five back-end stages: difference, gain
//  multiply, clamp, reciprocal multiply, correction and output register.
//  Input stalls only while two finished channels wait behind a stalled output.
//  Reset is asynchronous, active low; configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_energy_top_sum #(
  parameter int NUM_SAMPLES = pets_pkg::NUM_SAMPLES_DEF,
  parameter int PED_SAMPLES = pets_pkg::PED_SAMPLES_DEF,
  parameter int TOP_COUNT   = pets_pkg::TOP_COUNT_DEF,
  parameter int ADC_BITS    = pets_pkg::ADC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [ADC_BITS-1:0]               sample_adc_i,
  input  wire logic [pets_pkg::TOT_W-1:0]        sample_tot_i,
  input  wire logic [pets_pkg::GAIN_W-1:0]       channel_gain_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [pets_pkg::ENERGY_W-1:0]   energy_out_o,
  output logic                                   tot_used_o,
  output logic                                   tot_over_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pets_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pets_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pets_pkg::*;

  localparam int PED_W  = ADC_BITS + $clog2(PED_SAMPLES + 1);
  localparam int TSUM_W = ADC_BITS + $clog2(TOP_COUNT + 1);
  localparam int FILL_W = $clog2(TOP_COUNT + 1);
  localparam int JOB_W  = $bits(job_meta_t) + GAIN_W + FILL_W + TSUM_W + PED_W;

  logic             tot_mode_q;
  logic [TOT_W-1:0] tot_thr_q;

  logic              push, pop, q_full, q_empty;
  logic [JOB_W-1:0]  q_wdata, q_rdata;
  logic [PED_W-1:0]  f_ped, b_ped;
  logic [TSUM_W-1:0] f_tsum, b_tsum;
  logic [FILL_W-1:0] f_fill, b_fill;
  logic [GAIN_W-1:0] f_gain, b_gain;
  job_meta_t         f_meta, b_meta;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_mode_q <= 1'b0;
      tot_thr_q  <= TOT_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TOT_MODE: begin
          tot_mode_q <= cfg_data_i[0];
        end
        REG_TOT_THRESHOLD: begin
          tot_thr_q <= cfg_data_i[TOT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pets_front #(
    .NUM_SAMPLES (NUM_SAMPLES),
    .PED_SAMPLES (PED_SAMPLES),
    .TOP_COUNT   (TOP_COUNT),
    .ADC_BITS    (ADC_BITS),
    .PED_W       (PED_W),
    .TSUM_W      (TSUM_W),
    .FILL_W      (FILL_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_adc_i    (sample_adc_i),
    .sample_tot_i    (sample_tot_i),
    .channel_gain_i  (channel_gain_i),
    .tot_mode_i      (tot_mode_q),
    .tot_threshold_i (tot_thr_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_ped_o       (f_ped),
    .job_tsum_o      (f_tsum),
    .job_fill_o      (f_fill),
    .job_gain_o      (f_gain),
    .job_meta_o      (f_meta)
  );

  assign q_wdata = {f_meta, f_gain, f_fill, f_tsum, f_ped};
  assign {b_meta, b_gain, b_fill, b_tsum, b_ped} = q_rdata;

  pets_fifo #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (q_wdata),
    .rd_en_i   (pop),
    .rd_data_o (q_rdata),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  pets_back #(
    .PED_SAMPLES (PED_SAMPLES),
    .TOP_COUNT   (TOP_COUNT),
    .ADC_BITS    (ADC_BITS),
    .PED_W       (PED_W),
    .TSUM_W      (TSUM_W),
    .FILL_W      (FILL_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .job_ped_i    (b_ped),
    .job_tsum_i   (b_tsum),
    .job_fill_i   (b_fill),
    .job_gain_i   (b_gain),
    .job_meta_i   (b_meta),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .energy_out_o (energy_out_o),
    .tot_used_o   (tot_used_o),
    .tot_over_o   (tot_over_o)
  );

endmodule

`default_nettype wire

@@ src/pets_checker.sv @@
// ----------------------------------------------------------------------------
// pets_checker
// Port-level checks of the pulse energy block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_energy_top_sum_assert.svh"

module pets_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [pets_pkg::ENERGY_W-1:0] energy_out_o,
  input wire logic                                tot_used_o,
  input wire logic                                tot_over_o
);
  import pets_pkg::*;

  // a result held under stall keeps its payload
  `PETS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(energy_out_o) && $stable(tot_used_o) && $stable(tot_over_o))

  // a ToT energy is a nonzero 12-bit value
  `PETS_ASSERT_IMP(a_tot_range, clk_i, rst_ni, out_valid_o && tot_used_o, (energy_out_o[ENERGY_W-1:TOT_W] == '0) && (energy_out_o != '0))

  // the job queue only fills up behind a result that is waiting
  `PETS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind pulse_energy_top_sum pets_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .energy_out_o (energy_out_o),
  .tot_used_o   (tot_used_o),
  .tot_over_o   (tot_over_o)
);

`default_nettype wire
